>>> src/lpps_pkg.sv
`default_nettype none
package lpps_pkg;

   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned LANES     = 3;
   localparam int unsigned PRODUCT_W = 22;
   localparam int unsigned TOTAL_W   = 23;
   localparam int unsigned WSUM_W    = 12;
   localparam int unsigned POS_W     = 12;
   localparam int unsigned ERR_W     = 13;
   localparam int unsigned GAIN_W    = 10;
   localparam int unsigned SPEED_W   = 9;
   localparam int unsigned LEVEL_W   = 10;
   localparam int unsigned DIV_STEPS = 23;
   localparam int unsigned DIV_CNT_W = 5;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [11:0] LANE_WEIGHT [LANES] = '{12'd1000, 12'd2000, 12'd3000};

   localparam logic [POS_W-1:0] CENTRE_POS = 12'd2000;
   localparam logic [POS_W-1:0] EDGE_HIGH  = 12'd4000;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_SPEED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_LINE_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_LEVEL   = 3'd5;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 10'd64;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST    = 10'd256;
   localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST  = 9'd125;
   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST   = 9'd125;
   localparam logic [LEVEL_W-1:0] ON_LINE_LEVEL_RST = 10'd500;
   localparam logic [LEVEL_W-1:0] NOISE_LEVEL_RST   = 10'd50;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIVIDE,
      ST_STEER,
      ST_DONE
   } lpps_state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] on_line_level;
      logic [LEVEL_W-1:0] noise_level;
   } lpps_lane_cfg_type;

   typedef struct packed {
      logic                  above_line;
      logic [SAMPLE_W-1:0]   kept;
      logic [PRODUCT_W-1:0]  product;
   } lpps_lane_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [SPEED_W-1:0] cruise_speed;
      logic [SPEED_W-1:0] speed_limit;
   } lpps_steer_cfg_type;

endpackage
`default_nettype wire

>>> src/lpps_lane.sv
`default_nettype none
module lpps_lane (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic [lpps_pkg::SAMPLE_W-1:0]       sample,
   input  wire logic [11:0]                         weight,
   input  wire lpps_pkg::lpps_lane_cfg_type         cfg,
   output lpps_pkg::lpps_lane_type                  lane
);

   lpps_pkg::lpps_lane_type lane_ff, lane_in;
   logic                    above_noise;

   always_comb begin
      above_noise        = sample > cfg.noise_level;
      lane_in.above_line = sample > cfg.on_line_level;
      lane_in.kept       = above_noise ? sample : '0;
      lane_in.product    = lpps_pkg::PRODUCT_W'(lane_in.kept * weight);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

   assign lane = lane_ff;

endmodule
`default_nettype wire

>>> src/lpps_div.sv
`default_nettype none
module lpps_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [lpps_pkg::TOTAL_W-1:0]      dividend,
   input  wire logic [lpps_pkg::WSUM_W-1:0]       divisor,
   output logic                                   done,
   output logic [lpps_pkg::POS_W-1:0]             quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lpps_pkg::DIV_CNT_W-1:0]    count_ff, count_in;
   logic [lpps_pkg::WSUM_W-1:0]       rem_ff, rem_in;
   logic [lpps_pkg::TOTAL_W-1:0]      quo_ff, quo_in;
   logic [lpps_pkg::WSUM_W-1:0]       dvs_ff, dvs_in;
   logic [lpps_pkg::WSUM_W:0]         trial;
   logic [lpps_pkg::WSUM_W:0]         diff;
   logic                              fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[lpps_pkg::TOTAL_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = trial >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = lpps_pkg::DIV_CNT_W'(lpps_pkg::DIV_STEPS);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[lpps_pkg::WSUM_W-1:0] : trial[lpps_pkg::WSUM_W-1:0];
         quo_in   = {quo_ff[lpps_pkg::TOTAL_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == lpps_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[lpps_pkg::POS_W-1:0];

endmodule
`default_nettype wire

>>> src/lpps_steer.sv
`default_nettype none
module lpps_steer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [lpps_pkg::POS_W-1:0]           position,
   input  wire logic signed [lpps_pkg::ERR_W-1:0]    prev_error,
   input  wire lpps_pkg::lpps_steer_cfg_type         cfg,
   output logic                                      done,
   output logic [lpps_pkg::SPEED_W-1:0]              left_speed,
   output logic [lpps_pkg::SPEED_W-1:0]              right_speed,
   output logic signed [lpps_pkg::ERR_W-1:0]         error
);

   logic signed [lpps_pkg::ERR_W-1:0]  err_c;
   logic signed [lpps_pkg::ERR_W:0]    derr_c;
   logic signed [23:0]                 p_prod_c;
   logic signed [24:0]                 d_prod_c;
   logic signed [10:0]                 kp_c;
   logic signed [10:0]                 kd_c;

   logic                               s1_valid_ff, s1_valid_in;
   logic signed [23:0]                 p_prod_ff;
   logic signed [24:0]                 d_prod_ff;
   logic signed [lpps_pkg::ERR_W-1:0]  err_ff;

   logic signed [23:0]                 p_adj;
   logic signed [24:0]                 d_adj;
   logic signed [17:0]                 diff_c;
   logic signed [18:0]                 left_sum;
   logic signed [18:0]                 right_sum;
   logic signed [18:0]                 max_ext;
   logic signed [18:0]                 base_ext;
   logic [lpps_pkg::SPEED_W-1:0]       left_in, right_in;

   logic                               done_ff;
   logic [lpps_pkg::SPEED_W-1:0]       left_ff, right_ff;

   // stage one: error terms and both products
   always_comb begin
      err_c       = $signed({1'b0, position}) - $signed({1'b0, lpps_pkg::CENTRE_POS});
      derr_c      = {err_c[lpps_pkg::ERR_W-1], err_c}
                  - {prev_error[lpps_pkg::ERR_W-1], prev_error};
      kp_c        = $signed({1'b0, cfg.prop_gain});
      kd_c        = $signed({1'b0, cfg.deriv_gain});
      p_prod_c    = 24'(err_c * kp_c);
      d_prod_c    = 25'(derr_c * kd_c);
      s1_valid_in = start;
   end

   // stage two: divide by 256 toward zero, sum, clamp
   always_comb begin
      p_adj     = p_prod_ff + $signed({16'd0, {8{p_prod_ff[23]}}});
      d_adj     = d_prod_ff + $signed({17'd0, {8{d_prod_ff[24]}}});
      diff_c    = {{2{p_adj[23]}}, p_adj[23:8]} + {d_adj[24], d_adj[24:8]};
      base_ext  = $signed({10'd0, cfg.cruise_speed});
      max_ext   = $signed({10'd0, cfg.speed_limit});
      left_sum  = base_ext + {diff_c[17], diff_c};
      right_sum = base_ext - {diff_c[17], diff_c};
      priority if (left_sum[18]) begin
         left_in = '0;
      end else if (left_sum > max_ext) begin
         left_in = cfg.speed_limit;
      end else begin
         left_in = left_sum[lpps_pkg::SPEED_W-1:0];
      end
      priority if (right_sum[18]) begin
         right_in = '0;
      end else if (right_sum > max_ext) begin
         right_in = cfg.speed_limit;
      end else begin
         right_in = right_sum[lpps_pkg::SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         done_ff     <= s1_valid_ff;
      end
      if (start) begin
         p_prod_ff <= p_prod_c;
         d_prod_ff <= d_prod_c;
         err_ff    <= err_c;
      end
      if (s1_valid_ff) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign done        = done_ff;
   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign error       = err_ff;

endmodule
`default_nettype wire

>>> src/line_position_pd_steering.sv
// a sensor that sees the line sends the item through the lane registers, the 23-step divider
// and the steering stages; an edge report skips the divider, a lost line skips both
// one item at a time: a new input transaction is taken only once the last result is loaded
// a result waiting in the output register does not stop the next item from entering
// reset: synchronous, active high; configuration registers return to their defaults, state to zero
`default_nettype none
module line_position_pd_steering (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [31:0]                         req_tdata,   // left_sample, centre_sample, right_sample
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [31:0]                              rsp_tdata,   // left_speed, right_speed, line_position
   output logic                                     rsp_tuser,   // line_found
   input  wire logic                                csr_we,
   input  wire logic [lpps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lpps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lpps_pkg::lpps_state_type              state_ff, state_in;

   logic [lpps_pkg::GAIN_W-1:0]           prop_gain_ff;
   logic [lpps_pkg::GAIN_W-1:0]           deriv_gain_ff;
   logic [lpps_pkg::SPEED_W-1:0]          cruise_speed_ff;
   logic [lpps_pkg::SPEED_W-1:0]          speed_limit_ff;
   logic [lpps_pkg::LEVEL_W-1:0]          on_line_level_ff;
   logic [lpps_pkg::LEVEL_W-1:0]          noise_level_ff;

   lpps_pkg::lpps_lane_cfg_type           lane_cfg;
   lpps_pkg::lpps_steer_cfg_type          steer_cfg;
   lpps_pkg::lpps_lane_type               lane [lpps_pkg::LANES];

   logic [lpps_pkg::TOTAL_W-1:0]          total;
   logic [lpps_pkg::WSUM_W-1:0]           wsum;
   logic                                  any_line;
   logic                                  lost;

   logic                                  lane_load;
   logic                                  div_start;
   logic                                  div_done;
   logic [lpps_pkg::POS_W-1:0]            quotient;
   logic                                  steer_start;
   logic                                  steer_done;
   logic [lpps_pkg::POS_W-1:0]            steer_pos;
   logic [lpps_pkg::SPEED_W-1:0]          left_speed, right_speed;
   logic signed [lpps_pkg::ERR_W-1:0]     steer_err;
   logic                                  out_free;
   logic                                  out_load;

   logic                                  lost_ff, lost_in;
   logic [lpps_pkg::POS_W-1:0]            pos_ff, pos_in;
   logic [lpps_pkg::POS_W-1:0]            prev_pos_ff, prev_pos_in;
   logic signed [lpps_pkg::ERR_W-1:0]     prev_err_ff, prev_err_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]                           rsp_data_ff, rsp_data_in;
   logic                                  rsp_user_ff, rsp_user_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= lpps_pkg::PROP_GAIN_RST;
         deriv_gain_ff    <= lpps_pkg::DERIV_GAIN_RST;
         cruise_speed_ff  <= lpps_pkg::CRUISE_SPEED_RST;
         speed_limit_ff   <= lpps_pkg::SPEED_LIMIT_RST;
         on_line_level_ff <= lpps_pkg::ON_LINE_LEVEL_RST;
         noise_level_ff   <= lpps_pkg::NOISE_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lpps_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
            lpps_pkg::CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata;
            lpps_pkg::CSR_CRUISE_SPEED:  cruise_speed_ff  <= csr_wdata[lpps_pkg::SPEED_W-1:0];
            lpps_pkg::CSR_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata[lpps_pkg::SPEED_W-1:0];
            lpps_pkg::CSR_ON_LINE_LEVEL: on_line_level_ff <= csr_wdata;
            lpps_pkg::CSR_NOISE_LEVEL:   noise_level_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      lane_cfg.on_line_level = on_line_level_ff;
      lane_cfg.noise_level   = noise_level_ff;
      steer_cfg.prop_gain    = prop_gain_ff;
      steer_cfg.deriv_gain   = deriv_gain_ff;
      steer_cfg.cruise_speed = cruise_speed_ff;
      steer_cfg.speed_limit  = speed_limit_ff;
   end

   // one lane per sensor
   for (genvar g = 0; g < lpps_pkg::LANES; g++) begin : g_lane
      lpps_lane u_lane (
         .clock  (clock),
         .load   (lane_load),
         .sample (req_tdata[g*lpps_pkg::SAMPLE_W +: lpps_pkg::SAMPLE_W]),
         .weight (lpps_pkg::LANE_WEIGHT[g]),
         .cfg    (lane_cfg),
         .lane   (lane[g])
      );
   end

   // merge of the lane results
   always_comb begin
      total    = lpps_pkg::TOTAL_W'(lane[0].product) + lpps_pkg::TOTAL_W'(lane[1].product)
               + lpps_pkg::TOTAL_W'(lane[2].product);
      wsum     = lpps_pkg::WSUM_W'(lane[0].kept) + lpps_pkg::WSUM_W'(lane[1].kept)
               + lpps_pkg::WSUM_W'(lane[2].kept);
      any_line = lane[0].above_line | lane[1].above_line | lane[2].above_line;
      lost     = wsum == '0;
   end

   lpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total),
      .divisor  (wsum),
      .done     (div_done),
      .quotient (quotient)
   );

   lpps_steer u_steer (
      .clock       (clock),
      .reset       (reset),
      .start       (steer_start),
      .position    (steer_pos),
      .prev_error  (prev_err_ff),
      .cfg         (steer_cfg),
      .done        (steer_done),
      .left_speed  (left_speed),
      .right_speed (right_speed),
      .error       (steer_err)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpps_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lpps_pkg::ST_MERGE;
            end
         end
         lpps_pkg::ST_MERGE: begin
            priority if (lost) begin
               state_in = lpps_pkg::ST_DONE;
            end else if (!any_line) begin
               state_in = lpps_pkg::ST_STEER;
            end else begin
               state_in = lpps_pkg::ST_DIVIDE;
            end
         end
         lpps_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = lpps_pkg::ST_STEER;
            end
         end
         lpps_pkg::ST_STEER: begin
            if (steer_done) begin
               state_in = lpps_pkg::ST_DONE;
            end
         end
         lpps_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = lpps_pkg::ST_IDLE;
            end
         end
         default: state_in = lpps_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready  = 1'b0;
      div_start   = 1'b0;
      steer_start = 1'b0;
      steer_pos   = quotient;
      out_load    = 1'b0;
      unique case (state_ff)
         lpps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         lpps_pkg::ST_MERGE: begin
            div_start   = !lost && any_line;
            steer_start = !lost && !any_line;
            steer_pos   = (prev_pos_ff < lpps_pkg::CENTRE_POS) ? '0 : lpps_pkg::EDGE_HIGH;
         end
         lpps_pkg::ST_DIVIDE: begin
            steer_start = div_done;
         end
         lpps_pkg::ST_STEER: ;
         lpps_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: ;
      endcase
      lane_load = req_tready && req_tvalid;
   end

   // item state and line history
   always_comb begin
      lost_in     = lost_ff;
      pos_in      = pos_ff;
      prev_pos_in = prev_pos_ff;
      prev_err_in = prev_err_ff;
      if (state_ff == lpps_pkg::ST_MERGE) begin
         lost_in = lost;
      end
      if (steer_start) begin
         pos_in = steer_pos;
      end
      if (state_ff == lpps_pkg::ST_DIVIDE && div_done) begin
         prev_pos_in = quotient;
      end
      if (out_load && !lost_ff) begin
         prev_err_in = steer_err;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = !lost_ff;
         if (lost_ff) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in = {2'b00, pos_ff, right_speed, left_speed};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpps_pkg::ST_IDLE;
         prev_pos_ff  <= '0;
         prev_err_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         lost_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_pos_ff  <= prev_pos_in;
         prev_err_ff  <= prev_err_in;
         rsp_valid_ff <= rsp_valid_in;
         lost_ff      <= lost_in;
      end
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

>>> src/lpps_chk.sv
`default_nettype none
module lpps_chk (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [31:0]  req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic         rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [9:0]   csr_wdata
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, csr_we, csr_index, csr_wdata};

   // one item in flight: no input transaction in the cycle after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in flight");

   // a lost line carries all-zero speeds and position
   a_lost_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("lost-line result not zero");

   // position never beyond the right edge, top two bits zero
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[29:18] <= 12'd4000 && rsp_tdata[31:30] == 2'b00)
      else $error("line position out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind line_position_pd_steering lpps_chk u_lpps_chk (.*);
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;

   localparam int GAIN_SCALE     = 256;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [lpps_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      logic [lpps_pkg::POS_W-1:0]   position;
      logic                         found;
      logic [lpps_pkg::SPEED_W-1:0] right_speed;
      logic [lpps_pkg::SPEED_W-1:0] left_speed;
   } steer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_wdata = '0;

   line_position_pd_steering DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // register mirror and steering state
   logic [lpps_pkg::GAIN_W-1:0]  cfg_prop_gain     = lpps_pkg::PROP_GAIN_RST;
   logic [lpps_pkg::GAIN_W-1:0]  cfg_deriv_gain    = lpps_pkg::DERIV_GAIN_RST;
   logic [lpps_pkg::SPEED_W-1:0] cfg_cruise_speed  = lpps_pkg::CRUISE_SPEED_RST;
   logic [lpps_pkg::SPEED_W-1:0] cfg_speed_limit   = lpps_pkg::SPEED_LIMIT_RST;
   logic [lpps_pkg::LEVEL_W-1:0] cfg_on_line_level = lpps_pkg::ON_LINE_LEVEL_RST;
   logic [lpps_pkg::LEVEL_W-1:0] cfg_noise_level   = lpps_pkg::NOISE_LEVEL_RST;
   int last_line_pos = 0;
   int last_error    = 0;

   logic [29:0]      pending_samples [$];
   steer_result_type steer_expected [$];
   int mismatches = 0;
   int results_seen = 0;
   int idle_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int clamp_speed(input int v);
      if (v < 0) return 0;
      if (v > int'(cfg_speed_limit)) return int'(cfg_speed_limit);
      return v;
   endfunction

   function automatic steer_result_type predict_steering(input logic [29:0] samples);
      logic [lpps_pkg::SAMPLE_W-1:0] smp [3];
      int wtotal, wsum, pos, err, diff, lspd, rspd;
      bit seen;
      steer_result_type res;
      smp[0] = samples[9:0];
      smp[1] = samples[19:10];
      smp[2] = samples[29:20];
      wtotal = 0;
      wsum = 0;
      seen = 1'b0;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         if (smp[i] > cfg_on_line_level) seen = 1'b1;
         if (smp[i] > cfg_noise_level) begin
            wtotal += int'(smp[i]) * 1000 * (i + 1);
            wsum += int'(smp[i]);
         end
      end
      if (wsum == 0) return res;
      if (!seen) begin
         pos = (last_line_pos < int'(lpps_pkg::CENTRE_POS)) ? 0 : int'(lpps_pkg::EDGE_HIGH);
      end else begin
         pos = (wtotal / wsum) & 12'hFFF;
         last_line_pos = pos;
      end
      err = pos - int'(lpps_pkg::CENTRE_POS);
      diff = (err * int'(cfg_prop_gain)) / GAIN_SCALE
           + ((err - last_error) * int'(cfg_deriv_gain)) / GAIN_SCALE;
      last_error = err;
      lspd = clamp_speed(int'(cfg_cruise_speed) + diff);
      rspd = clamp_speed(int'(cfg_cruise_speed) - diff);
      res.left_speed  = lspd[lpps_pkg::SPEED_W-1:0];
      res.right_speed = rspd[lpps_pkg::SPEED_W-1:0];
      res.found       = 1'b1;
      res.position    = pos[lpps_pkg::POS_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // sender: bursts of transactions separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            steer_expected.push_back(predict_steering(req_tdata[29:0]));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tdata <= {2'b00, pending_samples.pop_front()};
               req_tvalid <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result transaction, stalls on its own pattern
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   int next_hold_at = 200;
   steer_result_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (steer_expected.size() == 0) begin
               report_mismatch("unexpected result position", rsp_tdata[29:18], -1);
            end else begin
               want = steer_expected.pop_front();
               if (rsp_tdata[8:0] !== want.left_speed)
                  report_mismatch("left_speed", rsp_tdata[8:0], want.left_speed);
               if (rsp_tdata[17:9] !== want.right_speed)
                  report_mismatch("right_speed", rsp_tdata[17:9], want.right_speed);
               if (rsp_tuser !== want.found)
                  report_mismatch("line_found", rsp_tuser, want.found);
               if (rsp_tdata[29:18] !== want.position)
                  report_mismatch("line_position", rsp_tdata[29:18], want.position);
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         if (results_seen == next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at += 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(input logic [lpps_pkg::CSR_IDX_W-1:0] idx, input int value);
      logic [9:0] v;
      v = value[9:0];
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         lpps_pkg::CSR_PROP_GAIN:     cfg_prop_gain = v;
         lpps_pkg::CSR_DERIV_GAIN:    cfg_deriv_gain = v;
         lpps_pkg::CSR_CRUISE_SPEED:  cfg_cruise_speed = v[lpps_pkg::SPEED_W-1:0];
         lpps_pkg::CSR_SPEED_LIMIT:   cfg_speed_limit = v[lpps_pkg::SPEED_W-1:0];
         lpps_pkg::CSR_ON_LINE_LEVEL: cfg_on_line_level = v;
         lpps_pkg::CSR_NOISE_LEVEL:   cfg_noise_level = v;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int prop, input int deriv, input int base,
                                 input int maxs, input int on_line, input int noise);
      write_csr(lpps_pkg::CSR_PROP_GAIN, prop);
      write_csr(lpps_pkg::CSR_DERIV_GAIN, deriv);
      write_csr(lpps_pkg::CSR_CRUISE_SPEED, base);
      write_csr(lpps_pkg::CSR_SPEED_LIMIT, maxs);
      write_csr(lpps_pkg::CSR_ON_LINE_LEVEL, on_line);
      write_csr(lpps_pkg::CSR_NOISE_LEVEL, noise);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_item(input int l, input int c, input int r);
      pending_samples.push_back({r[9:0], c[9:0], l[9:0]});
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_tvalid || steer_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_level(input int lo, input int hi);
      if (lo > 1023) lo = 1023;
      if (hi > 1023) hi = 1023;
      if (lo > hi) return $urandom_range(0, 1023);
      return $urandom_range(lo, hi);
   endfunction

   function automatic logic [29:0] make_sample();
      int s [3];
      int kind, peak, noise, on_line;
      noise = int'(cfg_noise_level);
      on_line = int'(cfg_on_line_level);
      kind = $urandom_range(0, 99);
      peak = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         if (kind < 10) begin
            s[i] = $urandom_range(0, 1023);
         end else if (kind < 20) begin
            s[i] = pick_level(0, noise);
         end else if (kind < 35) begin
            s[i] = pick_level(noise + 1, on_line);
         end else if (kind < 40) begin
            case ($urandom_range(0, 5))
               0: s[i] = noise;
               1: s[i] = (noise + 1) & 10'h3FF;
               2: s[i] = on_line;
               3: s[i] = (on_line + 1) & 10'h3FF;
               4: s[i] = 0;
               default: s[i] = 1023;
            endcase
         end else if (i == peak) begin
            s[i] = pick_level(on_line + 1, 1023);
         end else begin
            case ($urandom_range(0, 2))
               0: s[i] = pick_level(0, noise);
               1: s[i] = pick_level(noise + 1, on_line);
               default: s[i] = $urandom_range(0, 1023);
            endcase
         end
      end
      return {s[2][9:0], s[1][9:0], s[0][9:0]};
   endfunction

   task automatic run_random(input int count);
      repeat (count) pending_samples.push_back(make_sample());
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default registers, edge reports on both sides, thresholds exactly met
      add_item(100, 100, 100);
      add_item(0, 0, 0);
      add_item(50, 50, 50);
      add_item(1000, 0, 0);
      add_item(0, 1000, 0);
      add_item(0, 0, 1000);
      add_item(0, 0, 200);
      add_item(500, 500, 500);
      add_item(1023, 1023, 1023);
      add_item(0, 0, 200);
      add_item(501, 51, 0);
      add_item(1023, 0, 0);
      add_item(200, 0, 0);
      add_item(10'h2AA, 10'h155, 10'h3FF);
      add_item(10'h155, 10'h2AA, 0);
      add_item(1000, 0, 1000);
      add_item(0, 51, 1023);
      wait_idle();
      run_random(120);
      run_random(120);

      // line level below noise level: above line but nothing kept
      apply_settings(64, 256, 125, 125, 20, 800);
      add_item(0, 30, 0);
      add_item(790, 800, 100);
      add_item(801, 0, 0);
      add_item(0, 0, 900);
      wait_idle();
      run_random(100);

      apply_settings(1023, 1023, 400, 400, 500, 50);
      run_random(120);
      apply_settings(0, 0, 0, 0, 0, 0);
      run_random(100);
      apply_settings(1023, 0, 511, 511, 1000, 1000);
      run_random(100);
      apply_settings(0, 1023, 300, 200, 0, 1023);
      write_csr(CSR_UNUSED_INDEX, 10'h3FF);
      @(posedge clock);
      csr_we <= 1'b0;
      run_random(100);
      apply_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1023, 1023);
      run_random(100);
      repeat (4) begin
         apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 1023), $urandom_range(0, 400));
         run_random(100);
      end
      apply_settings(64, 256, 125, 125, 500, 50);
      run_random(70);

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
